@@ src/cwbt_pkg.sv @@
// ----------------------------------------------------------------------------
// cwbt_pkg
// Shared types and constants of the channel word to time sample transposer.
// ----------------------------------------------------------------------------
package cwbt_pkg;

   // sample and channel geometry
   localparam int SAMPLE_W     = 16;
   localparam int WORD_W       = 16;
   localparam int CHANNEL_MAX  = 16;
   localparam int CHAN_IDX_W   = 4;
   localparam int CHAN_CNT_W   = 5;
   localparam int BANK_COUNT   = 4;
   localparam int BANK_IDX_W   = 2;
   localparam int LANE_IDX_W   = 2;
   localparam int BANK_W       = 64;

   // configuration port
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 64;

   // group queue between the front and the back
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MASK_BANK_0   = 3'd0,
      CSR_MASK_BANK_1   = 3'd1,
      CSR_MASK_BANK_2   = 3'd2,
      CSR_MASK_BANK_3   = 3'd3,
      CSR_CHANNEL_COUNT = 3'd4
   } csr_index_type;

   // group queue status
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

@@ src/channel_word_bit_transposer.sv @@
// ----------------------------------------------------------------------------
// channel_word_bit_transposer
// Logic-analyser deinterleaver: turns round-robin channel words into time
// ordered samples, one group of SLOTS_PER_WORD samples per channel round.
// ----------------------------------------------------------------------------
//  channel | ports                                   | moves
//  --------+-----------------------------------------+---------------------
//  req     | req_valid/req_ready, req_sample_word    | one channel word
//  rsp     | rsp_valid/rsp_ready, rsp_sample_value,  | one time slot sample
//          | rsp_last_of_group                       |
//  csr     | csr_wr_en, csr_index, csr_wdata         | one register write
//
// a word is taken every cycle; the word that closes a group waits only
// while both queue entries are full
// a group leaves at one sample per cycle while rsp_ready stays high,
// through the single output register of the back end
// a closed group passes a queue entry, grp_ff and the output register
// synchronous active-high reset clears the accumulators, queue and
// channel index; masks reset to zero, channel count to sixteen
// ----------------------------------------------------------------------------
module channel_word_bit_transposer #(
   parameter int SLOTS_PER_WORD = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [cwbt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cwbt_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [cwbt_pkg::WORD_W-1:0]           req_sample_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [cwbt_pkg::SAMPLE_W-1:0]         rsp_sample_value,
   output logic                                  rsp_last_of_group
);
   import cwbt_pkg::*;

   logic                                         push_valid;
   logic [SLOTS_PER_WORD-1:0][SAMPLE_W-1:0]      push_group;
   logic [SLOTS_PER_WORD-1:0][SAMPLE_W-1:0]      pop_group;
   logic                                         pop_ready;
   q_status_type                                 q_status;

   // word intake and accumulation
   cwbt_front #(
      .SLOTS_PER_WORD (SLOTS_PER_WORD)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_word (req_sample_word),
      .push_valid      (push_valid),
      .push_group      (push_group),
      .q_status        (q_status)
   );

   // finished groups
   cwbt_group_queue #(
      .SLOTS_PER_WORD (SLOTS_PER_WORD)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_group (push_group),
      .pop_ready  (pop_ready),
      .pop_group  (pop_group),
      .q_status   (q_status)
   );

   // sample drain
   cwbt_back #(
      .SLOTS_PER_WORD (SLOTS_PER_WORD)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .pop_group         (pop_group),
      .pop_ready         (pop_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_last_of_group (rsp_last_of_group)
   );

   // front never pushes into a full queue
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_status.full)
      else $error("group pushed into full queue");

   // queue cannot be full and empty at once
   a_status_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue status inconsistent");

   // a closed group is held in the queue on the next cycle
   a_group_held: assert property (@(posedge clock) disable iff (reset)
      push_valid |=> !q_status.empty)
      else $error("closed group lost");

endmodule

@@ src/cwbt_front.sv @@
// ----------------------------------------------------------------------------
// cwbt_front
// Takes channel words, ORs the channel mask into the slot accumulators and
// hands each finished group to the queue. Also holds the config registers.
// ----------------------------------------------------------------------------
module cwbt_front #(
   parameter int SLOTS_PER_WORD = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration writes
   input  logic                                  csr_wr_en,
   input  logic [cwbt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cwbt_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // incoming words
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [cwbt_pkg::WORD_W-1:0]           req_sample_word,
   // finished groups
   output logic                                  push_valid,
   output logic [SLOTS_PER_WORD-1:0][cwbt_pkg::SAMPLE_W-1:0] push_group,
   input  cwbt_pkg::q_status_type                q_status
);
   import cwbt_pkg::*;

   logic [BANK_COUNT-1:0][BANK_W-1:0]            mask_ff;
   logic [CHAN_CNT_W-1:0]                        count_ff;
   logic [CHAN_IDX_W-1:0]                        chan_ff;
   logic [CHAN_IDX_W-1:0]                        chan_in;
   logic [SLOTS_PER_WORD-1:0][SAMPLE_W-1:0]      acc_ff;
   logic [SLOTS_PER_WORD-1:0][SAMPLE_W-1:0]      acc_in;
   logic [SLOTS_PER_WORD-1:0][SAMPLE_W-1:0]      acc_sum;
   logic [SLOTS_PER_WORD-1:0]                    hit;
   logic [CHAN_CNT_W-1:0]                        eff_count;
   logic [CHAN_CNT_W-1:0]                        chan_next;
   logic [SAMPLE_W-1:0]                          chan_mask;
   logic                                         group_end;
   logic                                         accept;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         count_ff <= CHAN_CNT_W'(CHANNEL_MAX);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MASK_BANK_0:   mask_ff[0] <= csr_wdata;
            CSR_MASK_BANK_1:   mask_ff[1] <= csr_wdata;
            CSR_MASK_BANK_2:   mask_ff[2] <= csr_wdata;
            CSR_MASK_BANK_3:   mask_ff[3] <= csr_wdata;
            CSR_CHANNEL_COUNT: count_ff   <= csr_wdata[CHAN_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // zero counts as one channel, anything above sixteen as sixteen
   always_comb begin
      if (count_ff == '0) begin
         eff_count = CHAN_CNT_W'(1);
      end else if (count_ff > CHAN_CNT_W'(CHANNEL_MAX)) begin
         eff_count = CHAN_CNT_W'(CHANNEL_MAX);
      end else begin
         eff_count = count_ff;
      end
   end

   // group ends on the last channel, or beyond it if the count dropped
   assign chan_next = {1'b0, chan_ff} + CHAN_CNT_W'(1);
   assign group_end = chan_next >= eff_count;

   // mask of the current channel
   assign chan_mask = mask_ff[chan_ff[CHAN_IDX_W-1 -: BANK_IDX_W]]
                             [chan_ff[LANE_IDX_W-1:0] * SAMPLE_W +: SAMPLE_W];

   // slot s takes word bit SLOTS_PER_WORD-1-s, missing bits read as zero
   for (genvar s = 0; s < SLOTS_PER_WORD; s++) begin : g_slot
      if (SLOTS_PER_WORD - 1 - s < WORD_W) begin : g_bit
         assign hit[s] = req_sample_word[SLOTS_PER_WORD-1-s];
      end else begin : g_zero
         assign hit[s] = 1'b0;
      end
      assign acc_sum[s] = acc_ff[s] | (hit[s] ? chan_mask : '0);
   end

   // a word that ends a group needs a free queue entry
   assign req_ready  = !group_end || !q_status.full;
   assign accept     = req_valid && req_ready;
   assign push_valid = accept && group_end;
   assign push_group = acc_sum;

   // accumulator and channel index update
   always_comb begin
      acc_in  = acc_ff;
      chan_in = chan_ff;
      if (accept) begin
         if (group_end) begin
            acc_in  = '0;
            chan_in = '0;
         end else begin
            acc_in  = acc_sum;
            chan_in = chan_next[CHAN_IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         chan_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         chan_ff <= chan_in;
      end
   end

endmodule

@@ src/cwbt_group_queue.sv @@
// ----------------------------------------------------------------------------
// cwbt_group_queue
// Short queue of finished sample groups between the front and the back.
// ----------------------------------------------------------------------------
module cwbt_group_queue #(
   parameter int SLOTS_PER_WORD = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push_valid,
   input  logic [SLOTS_PER_WORD-1:0][cwbt_pkg::SAMPLE_W-1:0] push_group,
   input  logic                                  pop_ready,
   output logic [SLOTS_PER_WORD-1:0][cwbt_pkg::SAMPLE_W-1:0] pop_group,
   output cwbt_pkg::q_status_type                q_status
);
   import cwbt_pkg::*;

   logic [SLOTS_PER_WORD-1:0][SAMPLE_W-1:0]      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]                            wr_ptr_ff;
   logic [QPTR_W-1:0]                            rd_ptr_ff;
   logic [QCNT_W-1:0]                            count_ff;
   logic                                         do_push;
   logic                                         do_pop;

   assign q_status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign do_push = push_valid && !q_status.full;
   assign do_pop  = pop_ready && !q_status.empty;
   assign pop_group = entry_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ src/cwbt_back.sv @@
// ----------------------------------------------------------------------------
// cwbt_back
// Drains one group at a time, in time order, one slot per cycle unless
// the output stalls, via an output register; flags each group's final slot.
// ----------------------------------------------------------------------------
module cwbt_back #(
   parameter int SLOTS_PER_WORD = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cwbt_pkg::q_status_type                q_status,
   input  logic [SLOTS_PER_WORD-1:0][cwbt_pkg::SAMPLE_W-1:0] pop_group,
   output logic                                  pop_ready,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [cwbt_pkg::SAMPLE_W-1:0]         rsp_sample_value,
   output logic                                  rsp_last_of_group
);
   import cwbt_pkg::*;

   localparam int SLOT_IDX_W = $clog2(SLOTS_PER_WORD);

   logic [SLOTS_PER_WORD-1:0][SAMPLE_W-1:0]      grp_ff;
   logic [SLOTS_PER_WORD-1:0][SAMPLE_W-1:0]      grp_in;
   logic [SLOT_IDX_W-1:0]                        slot_ff;
   logic [SLOT_IDX_W-1:0]                        slot_in;
   logic                                         busy_ff;
   logic                                         busy_in;
   logic                                         valid_ff;
   logic                                         valid_in;
   logic [SAMPLE_W-1:0]                          value_ff;
   logic                                         last_ff;
   logic                                         out_free;
   logic                                         emit;
   logic                                         last_slot;
   logic                                         finish;
   logic                                         load;

   // emit when the output register is empty or being taken
   assign out_free  = !valid_ff || rsp_ready;
   assign emit      = busy_ff && out_free;
   assign last_slot = slot_ff == SLOT_IDX_W'(SLOTS_PER_WORD - 1);
   assign finish    = emit && last_slot;
   assign pop_ready = !busy_ff || finish;
   assign load      = pop_ready && !q_status.empty;

   // group shift register, slot counter and busy flag
   always_comb begin
      grp_in  = grp_ff;
      slot_in = slot_ff;
      busy_in = busy_ff;
      if (load) begin
         grp_in  = pop_group;
         slot_in = '0;
         busy_in = 1'b1;
      end else if (emit) begin
         for (int s = 0; s < SLOTS_PER_WORD - 1; s++) begin
            grp_in[s] = grp_ff[s+1];
         end
         slot_in = slot_ff + 1'b1;
         busy_in = !last_slot;
      end
   end

   assign valid_in = out_free ? emit : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      if (emit) begin
         value_ff <= grp_ff[0];
         last_ff  <= last_slot;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_sample_value  = value_ff;
   assign rsp_last_of_group = last_ff;

endmodule

@@ tb/channel_word_bit_transposer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// channel_word_bit_transposer_test
// Self-checking bench for the channel word to time sample transposer: a queue
// fed driver offers channel words, a clocked monitor folds every accepted word
// into a local copy of the slot accumulators and compares each emitted sample
// with the oldest predicted one. Masks and channel count are changed between
// phases while the block is drained.
// ----------------------------------------------------------------------------
module channel_word_bit_transposer_test;
   import cwbt_pkg::*;

   localparam int SLOTS       = 16;
   localparam int QUIET_LIMIT = 1000;
   localparam int STALL_LONG  = 150;
   localparam int RANDOM_WORDS = 80;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                last;
   } slot_sample_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [WORD_W-1:0]      req_sample_word = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_sample_value;
   logic                   rsp_last_of_group;

   // local copy of the block state and registers
   logic [BANK_W-1:0]      mask_bank [BANK_COUNT];
   logic [CHAN_CNT_W-1:0]  chan_count;
   logic [SAMPLE_W-1:0]    slot_acc [SLOTS];
   logic [CHAN_IDX_W-1:0]  chan_idx;

   slot_sample_type        due_samples [$];
   logic [WORD_W-1:0]      word_backlog [$];

   int  words_issued = 0;
   int  words_taken = 0;
   int  mismatches = 0;
   int  quiet_cycles = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  req_gap_max = 8;
   int  rsp_gap_max = 8;
   int  stall_request = 0;
   int  stall_left = 0;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;

   channel_word_bit_transposer #(
      .SLOTS_PER_WORD (SLOTS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_word   (req_sample_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_last_of_group (rsp_last_of_group)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // fold one channel word into the slots, emit the group when it closes
   function automatic void absorb_word(input logic [WORD_W-1:0] word);
      logic [SAMPLE_W-1:0] lane;
      int                  eff;
      int                  pos;
      slot_sample_type     smp;
      lane = SAMPLE_W'(mask_bank[chan_idx[3:2]] >> (16 * chan_idx[1:0]));
      for (int s = 0; s < SLOTS; s++) begin
         pos = SLOTS - 1 - s;
         if (pos < WORD_W && word[pos]) begin
            slot_acc[s] = slot_acc[s] | lane;
         end
      end
      if (chan_count == 0) eff = 1;
      else if (chan_count > CHANNEL_MAX) eff = CHANNEL_MAX;
      else eff = chan_count;
      if (int'(chan_idx) + 1 >= eff) begin
         for (int s = 0; s < SLOTS; s++) begin
            smp.value = slot_acc[s];
            smp.last  = (s == SLOTS - 1);
            due_samples.push_back(smp);
            slot_acc[s] = '0;
         end
         chan_idx = '0;
      end else begin
         chan_idx = chan_idx + 1'b1;
      end
   endfunction

   // register write, mirrored into the local copy
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx < BANK_COUNT) mask_bank[idx[BANK_IDX_W-1:0]] = data;
      else if (idx == CSR_CHANNEL_COUNT) chan_count = data[CHAN_CNT_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_word(input logic [WORD_W-1:0] word);
      word_backlog.push_back(word);
      words_issued++;
   endtask

   // wait until every word is taken and every sample has left, then linger
   task automatic wait_drained(input int tail);
      while (words_taken != words_issued || due_samples.size() != 0)
         @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 5))
         0: pick_word = '0;
         1: pick_word = '1;
         2: pick_word = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
         default: pick_word = WORD_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // new settings, then whole groups plus at most one partial group left open
   task automatic random_phase(output int sent);
      logic [CHAN_CNT_W-1:0] cnt;
      int                    eff;
      int                    total;
      for (int b = 0; b < BANK_COUNT; b++) begin
         case ($urandom_range(0, 5))
            0: ;
            1: csr_write(CSR_INDEX_W'(CSR_MASK_BANK_0 + b), '0);
            2: csr_write(CSR_INDEX_W'(CSR_MASK_BANK_0 + b), '1);
            default: csr_write(CSR_INDEX_W'(CSR_MASK_BANK_0 + b), {$urandom, $urandom});
         endcase
      end
      case ($urandom_range(0, 9))
         0: cnt = '0;
         1: cnt = CHAN_CNT_W'($urandom_range(17, 31));
         2: cnt = CHAN_CNT_W'(CHANNEL_MAX);
         default: cnt = CHAN_CNT_W'($urandom_range(1, 8));
      endcase
      csr_write(CSR_CHANNEL_COUNT, CSR_DATA_W'(cnt));
      if (cnt == 0) eff = 1;
      else if (cnt > CHANNEL_MAX) eff = CHANNEL_MAX;
      else eff = cnt;
      req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      total = $urandom_range(1, 3) * eff + $urandom_range(0, eff - 1);
      for (int k = 0; k < total; k++) send_word(pick_word());
      sent = total;
      wait_drained(8);
   endtask

   // sender: offers backlog items, with a drawn gap after each
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (word_backlog.size() != 0) begin
            req_valid <= 1'b1;
            req_sample_word <= word_backlog.pop_front();
            req_gap = $urandom_range(0, req_gap_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: drawn wait after each item, plus long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_request != 0) begin
            stall_left = stall_request;
            stall_request = 0;
         end
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_gap = $urandom_range(0, rsp_gap_max);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: check samples, predict from accepted words
   always @(posedge clock) begin
      slot_sample_type due;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            if (due_samples.size() == 0) begin
               $error("unexpected sample_value %h last_of_group %b",
                      rsp_sample_value, rsp_last_of_group);
               mismatches++;
            end else begin
               due = due_samples.pop_front();
               if (rsp_sample_value !== due.value) begin
                  $error("sample_value: expected %h, got %h", due.value, rsp_sample_value);
                  mismatches++;
               end
               if (rsp_last_of_group !== due.last) begin
                  $error("last_of_group: expected %b, got %b", due.last, rsp_last_of_group);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            absorb_word(req_sample_word);
            words_taken++;
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [BANK_W-1:0] bank;
      int                sent;
      int                random_sent;
      random_sent = 0;
      for (int b = 0; b < BANK_COUNT; b++) mask_bank[b] = '0;
      for (int s = 0; s < SLOTS; s++) slot_acc[s] = '0;
      chan_count = CHAN_CNT_W'(CHANNEL_MAX);
      chan_idx = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one output bit per channel, full sixteen-channel group
      for (int b = 0; b < BANK_COUNT; b++) begin
         bank = '0;
         for (int l = 0; l < 4; l++)
            bank = bank | (BANK_W'(SAMPLE_W'(1) << (4 * b + l)) << (16 * l));
         csr_write(CSR_INDEX_W'(CSR_MASK_BANK_0 + b), bank);
      end
      send_word(16'hFFFF); send_word(16'h0000); send_word(16'h8000); send_word(16'h0001);
      send_word(16'hAAAA); send_word(16'h5555); send_word(16'h00FF); send_word(16'hFF00);
      send_word(16'h0F0F); send_word(16'hF0F0); send_word(16'h1234); send_word(16'h8001);
      send_word(16'h7FFE); send_word(16'hC003); send_word(16'h3C3C); send_word(16'hFFFF);
      wait_drained(8);

      // single channel, then a count of zero that acts as one
      csr_write(CSR_MASK_BANK_0, '1);
      csr_write(CSR_CHANNEL_COUNT, CSR_DATA_W'(1));
      send_word(16'hFFFF);
      send_word(16'h0000);
      wait_drained(8);
      csr_write(CSR_CHANNEL_COUNT, '0);
      send_word(16'h8001);
      wait_drained(8);

      // writes to unused indexes must change nothing
      for (int i = CSR_CHANNEL_COUNT + 1; i < 2 ** CSR_INDEX_W; i++)
         csr_write(CSR_INDEX_W'(i), '1);
      send_word(16'h4002);
      wait_drained(8);

      // count lowered while a group is open closes it on the next word
      csr_write(CSR_CHANNEL_COUNT, CSR_DATA_W'(4));
      send_word(16'hA5A5);
      send_word(16'h5A5A);
      send_word(16'h0FF0);
      wait_drained(8);
      csr_write(CSR_CHANNEL_COUNT, CSR_DATA_W'(2));
      send_word(16'hF00F);
      wait_drained(8);

      // receiver holds off while words keep coming, group queue fills
      csr_write(CSR_MASK_BANK_0, {$urandom, $urandom});
      csr_write(CSR_CHANNEL_COUNT, CSR_DATA_W'(1));
      req_gap_max = 0;
      stall_request = STALL_LONG;
      for (int k = 0; k < 10; k++) send_word(pick_word());
      wait_drained(8);

      while (random_sent < RANDOM_WORDS) begin
         random_phase(sent);
         random_sent += sent;
      end

      wait_drained(24);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
